### rtl/core/ata_pio_chs_sector_engine_assert.svh
// ----------------------------------------------------------------------------
// ata_pio_chs_sector_engine_assert.svh
// Assertion macros used by the sector engine controller
// ----------------------------------------------------------------------------
`ifndef ATA_PIO_CHS_SECTOR_ENGINE_ASSERT_SVH
`define ATA_PIO_CHS_SECTOR_ENGINE_ASSERT_SVH

`ifndef SYNTH

`define APS_ASSERT(lbl, ck, rn, prop) \
  lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
    else $error("%m: assertion failed");

`define APS_ASSERT_NEVER(lbl, ck, rn, expr) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(expr)) \
    else $error("%m: forbidden condition seen");

`else

`define APS_ASSERT(lbl, ck, rn, prop)

`define APS_ASSERT_NEVER(lbl, ck, rn, expr)

`endif

`endif

### rtl/core/aps_pkg.sv
// ----------------------------------------------------------------------------
// aps_pkg
// Types, codes and constants of the ATA PIO CHS sector engine
// ----------------------------------------------------------------------------
package aps_pkg;

  localparam int WORDS_PER_SECTOR = 256;
  localparam int LBA_BITS         = 28;
  localparam int WC_W      = (WORDS_PER_SECTOR > 1) ? $clog2(WORDS_PER_SECTOR) : 1;
  localparam int DIV_CNT_W = $clog2(LBA_BITS + 1);
  localparam int SPT_W     = 8;
  localparam int HC_W      = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADS = 2'd2;

  localparam logic [15:0]      BASE_RST  = 16'h01F0;
  localparam logic [SPT_W-1:0] SPT_RST   = 8'd17;
  localparam logic [HC_W-1:0]  HEADS_RST = 5'd15;

  // request codes
  localparam logic [1:0] CMD_READ   = 2'd0;
  localparam logic [1:0] CMD_WRITE  = 2'd1;
  localparam logic [1:0] CMD_STATUS = 2'd2;
  localparam logic [1:0] CMD_DATA   = 2'd3;

  // result kinds
  localparam logic [2:0] KIND_REG  = 3'd0;
  localparam logic [2:0] KIND_DWR  = 3'd1;
  localparam logic [2:0] KIND_SREQ = 3'd2;
  localparam logic [2:0] KIND_DREQ = 3'd3;
  localparam logic [2:0] KIND_HOST = 3'd4;
  localparam logic [2:0] KIND_DONE = 3'd5;
  localparam logic [2:0] KIND_REJ  = 3'd6;

  // task-file register offsets
  localparam logic [2:0] OFF_DATA     = 3'd0;
  localparam logic [2:0] OFF_COUNT    = 3'd2;
  localparam logic [2:0] OFF_SECTOR   = 3'd3;
  localparam logic [2:0] OFF_CYL_LO   = 3'd4;
  localparam logic [2:0] OFF_CYL_HI   = 3'd5;
  localparam logic [2:0] OFF_DEVICE   = 3'd6;
  localparam logic [2:0] OFF_CMD_STAT = 3'd7;

  localparam logic [7:0] ATA_READ_SECTOR  = 8'h20;
  localparam logic [7:0] ATA_WRITE_SECTOR = 8'h30;
  localparam logic [7:0] DEV_SEL_BASE     = 8'hA0;
  localparam int ST_BSY  = 7;
  localparam int ST_DRDY = 6;

  typedef struct packed {
    logic [1:0]          cmd;
    logic [LBA_BITS-1:0] lba;
    logic [15:0]         data_word;
    logic [7:0]          status_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] port_address;
    logic [15:0] port_value;
    logic        last;
  } out_item_t;

  // result selector; task-file writes run in order up to the status request
  typedef enum logic [3:0] {
    SEL_COUNT   = 4'd0,
    SEL_SECTOR  = 4'd1,
    SEL_CYL_LO  = 4'd2,
    SEL_CYL_HI  = 4'd3,
    SEL_DEVICE  = 4'd4,
    SEL_COMMAND = 4'd5,
    SEL_SREQ    = 4'd6,
    SEL_DREQ    = 4'd7,
    SEL_DWR     = 4'd8,
    SEL_HOST    = 4'd9,
    SEL_DONE    = 4'd10,
    SEL_REJ     = 4'd11
  } sel_t;

  typedef struct packed {
    logic load_item;
    logic div_start;
    logic div_second;
    logic set_write;
    logic write_val;
    logic clr_words;
    logic inc_words;
    logic emit;
    sel_t sel;
    logic last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic       bsy;
    logic       drdy;
    logic       is_write;
    logic       words_last;
    logic       div_done;
    logic       out_free;
  } dp_stat_t;

endpackage

### rtl/core/aps_div.sv
// ----------------------------------------------------------------------------
// aps_div
// Restoring divider, one quotient bit per cycle, for the LBA to CHS split
// ----------------------------------------------------------------------------
module aps_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic [aps_pkg::LBA_BITS-1:0] dividend_i,
  input  logic [aps_pkg::SPT_W-1:0]    divisor_i,
  output logic                         done_o,
  output logic [aps_pkg::LBA_BITS-1:0] quot_o,
  output logic [aps_pkg::SPT_W-1:0]    rem_o
);
  import aps_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [LBA_BITS-1:0]  quot_r, quot_nxt;
  logic [SPT_W-1:0]     rem_r, rem_nxt;
  logic [SPT_W-1:0]     dvs_r, dvs_nxt;
  logic [SPT_W:0]       trial;
  logic [SPT_W:0]       diff;
  logic                 ge;

  always_comb begin
    trial    = {rem_r, quot_r[LBA_BITS-1]};
    diff     = trial - {1'b0, dvs_r};
    ge       = (trial >= {1'b0, dvs_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start_i) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      quot_nxt = dividend_i;
      rem_nxt  = '0;
      dvs_nxt  = divisor_i;
    end else if (busy_r) begin
      rem_nxt  = ge ? diff[SPT_W-1:0] : trial[SPT_W-1:0];
      quot_nxt = {quot_r[LBA_BITS-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(LBA_BITS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    dvs_r  <= dvs_nxt;
  end

  assign done_o = done_r;
  assign quot_o = quot_r;
  assign rem_o  = rem_r;

endmodule

### rtl/core/aps_dp.sv
// ----------------------------------------------------------------------------
// aps_dp
// Datapath: geometry registers, item latch, CHS split, word count, result register
// ----------------------------------------------------------------------------
module aps_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  aps_pkg::in_item_t              in_data,
  input  logic                           cfg_valid,
  input  logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0] cfg_data,
  input  aps_pkg::ctrl_cmd_t             cmd_i,
  output aps_pkg::dp_stat_t              stat_o,
  output logic                           out_valid,
  input  logic                           out_ready,
  output aps_pkg::out_item_t             out_data
);
  import aps_pkg::*;

  logic [15:0]         base_r;
  logic [SPT_W-1:0]    spt_r;
  logic [HC_W-1:0]     heads_r;
  in_item_t            item_r;
  logic                pass2_r;
  logic [SPT_W-1:0]    sector_r;
  logic [3:0]          head_r;
  logic [15:0]         cyl_r;
  logic                is_write_r;
  logic [WC_W-1:0]     words_r;
  logic                out_valid_r, out_valid_nxt;
  out_item_t           out_data_r;
  out_item_t           res;

  logic [SPT_W-1:0]    spt_eff;
  logic [SPT_W-1:0]    hc_eff;
  logic [LBA_BITS-1:0] div_dividend;
  logic [SPT_W-1:0]    div_divisor;
  logic                div_done;
  logic [LBA_BITS-1:0] div_quot;
  logic [SPT_W-1:0]    div_rem;

  logic [2:0]          kind;
  logic [2:0]          off;
  logic [15:0]         val;
  logic                addr_en;

  // zero geometry counts as one
  assign spt_eff      = (spt_r == '0) ? SPT_W'(1) : spt_r;
  assign hc_eff       = (heads_r == '0) ? SPT_W'(1) : SPT_W'(heads_r);
  assign div_dividend = cmd_i.div_second ? div_quot : item_r.lba;
  assign div_divisor  = cmd_i.div_second ? hc_eff : spt_eff;

  aps_div u_div (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot),
    .rem_o      (div_rem)
  );

  always_comb begin
    kind    = KIND_REJ;
    off     = OFF_DATA;
    val     = '0;
    addr_en = 1'b0;
    case (cmd_i.sel)
      SEL_COUNT: begin
        kind = KIND_REG; off = OFF_COUNT; val = 16'd1; addr_en = 1'b1;
      end
      SEL_SECTOR: begin
        kind = KIND_REG; off = OFF_SECTOR; val = {8'd0, sector_r}; addr_en = 1'b1;
      end
      SEL_CYL_LO: begin
        kind = KIND_REG; off = OFF_CYL_LO; val = {8'd0, cyl_r[7:0]}; addr_en = 1'b1;
      end
      SEL_CYL_HI: begin
        kind = KIND_REG; off = OFF_CYL_HI; val = {8'd0, cyl_r[15:8]}; addr_en = 1'b1;
      end
      SEL_DEVICE: begin
        kind = KIND_REG; off = OFF_DEVICE; addr_en = 1'b1;
        val  = {8'd0, DEV_SEL_BASE | {4'd0, head_r}};
      end
      SEL_COMMAND: begin
        kind = KIND_REG; off = OFF_CMD_STAT; addr_en = 1'b1;
        val  = {8'd0, is_write_r ? ATA_WRITE_SECTOR : ATA_READ_SECTOR};
      end
      SEL_SREQ: begin
        kind = KIND_SREQ; off = OFF_CMD_STAT; addr_en = 1'b1;
      end
      SEL_DREQ: begin
        kind = KIND_DREQ; off = OFF_DATA; addr_en = 1'b1;
      end
      SEL_DWR: begin
        kind = KIND_DWR; off = OFF_DATA; val = item_r.data_word; addr_en = 1'b1;
      end
      SEL_HOST: begin
        kind = KIND_HOST; val = item_r.data_word;
      end
      SEL_DONE: begin
        kind = KIND_DONE;
      end
      default: begin
        kind = KIND_REJ;
      end
    endcase
    res.kind         = kind;
    res.port_address = addr_en ? (base_r + {13'd0, off}) : 16'd0;
    res.port_value   = val;
    res.last         = cmd_i.last;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd_i.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= BASE_RST;
      spt_r       <= SPT_RST;
      heads_r     <= HEADS_RST;
      pass2_r     <= 1'b0;
      sector_r    <= '0;
      head_r      <= '0;
      cyl_r       <= '0;
      is_write_r  <= 1'b0;
      words_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BASE:  base_r  <= cfg_data;
          CFG_SPT:   spt_r   <= cfg_data[SPT_W-1:0];
          CFG_HEADS: heads_r <= cfg_data[HC_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.div_start) begin
        pass2_r <= cmd_i.div_second;
      end
      if (div_done) begin
        if (pass2_r) begin
          head_r <= div_rem[3:0];
          cyl_r  <= div_quot[15:0];
        end else begin
          sector_r <= div_rem + 1'b1;
        end
      end
      if (cmd_i.set_write) begin
        is_write_r <= cmd_i.write_val;
      end
      if (cmd_i.clr_words) begin
        words_r <= '0;
      end else if (cmd_i.inc_words) begin
        words_r <= words_r + 1'b1;
      end
      out_valid_r <= out_valid_nxt;
    end
    if (cmd_i.load_item) begin
      item_r <= in_data;
    end
    if (cmd_i.emit) begin
      out_data_r <= res;
    end
  end

  assign stat_o.cmd        = item_r.cmd;
  assign stat_o.bsy        = item_r.status_byte[ST_BSY];
  assign stat_o.drdy       = item_r.status_byte[ST_DRDY];
  assign stat_o.is_write   = is_write_r;
  assign stat_o.words_last = (words_r == WC_W'(WORDS_PER_SECTOR - 1));
  assign stat_o.div_done   = div_done;
  assign stat_o.out_free   = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### rtl/core/aps_ctrl.sv
// ----------------------------------------------------------------------------
// aps_ctrl
// Controller: transfer phase tracking and result sequencing
// ----------------------------------------------------------------------------
`include "ata_pio_chs_sector_engine_assert.svh"

module aps_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  aps_pkg::dp_stat_t  stat_i,
  output aps_pkg::ctrl_cmd_t cmd_o
);
  import aps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_DECIDE = 5'b00010,
    S_DIV1   = 5'b00100,
    S_DIV2   = 5'b01000,
    S_EMIT   = 5'b10000
  } state_t;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_BUSY  = 5'b00010,
    PH_READY = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_END   = 5'b10000
  } phase_t;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  sel_t   cur_r, cur_nxt;
  sel_t   end_r, end_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cur_nxt   = cur_r;
    end_nxt   = end_r;
    cmd_o     = '0;
    cmd_o.sel  = cur_r;
    cmd_o.last = (cur_r == end_r);
    in_ready   = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd_o.load_item = 1'b1;
          state_nxt       = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt = S_EMIT;
        cur_nxt   = SEL_REJ;
        end_nxt   = SEL_REJ;
        case (phase_r)
          PH_IDLE: begin
            if (stat_i.cmd == CMD_READ || stat_i.cmd == CMD_WRITE) begin
              cmd_o.set_write = 1'b1;
              cmd_o.write_val = (stat_i.cmd == CMD_WRITE);
              cmd_o.clr_words = 1'b1;
              cmd_o.div_start = 1'b1;
              phase_nxt       = PH_BUSY;
              cur_nxt         = SEL_SREQ;
              end_nxt         = SEL_SREQ;
              state_nxt       = S_DIV1;
            end
          end
          PH_BUSY: begin
            if (stat_i.cmd == CMD_STATUS) begin
              end_nxt = SEL_SREQ;
              if (stat_i.bsy) begin
                cur_nxt = SEL_SREQ;
              end else begin
                cur_nxt   = SEL_COUNT;
                phase_nxt = PH_READY;
              end
            end
          end
          PH_READY: begin
            if (stat_i.cmd == CMD_STATUS) begin
              if (!stat_i.drdy) begin
                cur_nxt = SEL_SREQ;
                end_nxt = SEL_SREQ;
              end else begin
                phase_nxt       = PH_DATA;
                cmd_o.clr_words = 1'b1;
                cur_nxt         = SEL_DREQ;
                end_nxt         = SEL_DREQ;
                // write: host words come next, nothing to report
                if (stat_i.is_write) begin
                  state_nxt = S_IDLE;
                end
              end
            end
          end
          PH_DATA: begin
            if (stat_i.cmd == CMD_DATA) begin
              cmd_o.inc_words = 1'b1;
              cur_nxt = stat_i.is_write ? SEL_DWR : SEL_HOST;
              if (stat_i.words_last) begin
                end_nxt   = SEL_SREQ;
                phase_nxt = PH_END;
              end else begin
                end_nxt = stat_i.is_write ? SEL_DWR : SEL_DREQ;
              end
            end
          end
          PH_END: begin
            if (stat_i.cmd == CMD_STATUS) begin
              if (stat_i.drdy) begin
                cur_nxt   = SEL_DONE;
                end_nxt   = SEL_DONE;
                phase_nxt = PH_IDLE;
              end else begin
                cur_nxt = SEL_SREQ;
                end_nxt = SEL_SREQ;
              end
            end
          end
          default: ;
        endcase
      end
      S_DIV1: begin
        if (stat_i.div_done) begin
          cmd_o.div_start  = 1'b1;
          cmd_o.div_second = 1'b1;
          state_nxt        = S_DIV2;
        end
      end
      S_DIV2: begin
        cmd_o.div_second = 1'b1;
        if (stat_i.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (cur_r == end_r) begin
            state_nxt = S_IDLE;
          end else if (cur_r < SEL_SREQ) begin
            cur_nxt = sel_t'(cur_r + 4'd1);
          end else begin
            cur_nxt = end_r;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= PH_IDLE;
      cur_r   <= SEL_REJ;
      end_r   <= SEL_REJ;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      cur_r   <= cur_nxt;
      end_r   <= end_nxt;
    end
  end

  `APS_ASSERT(a_emit_has_room, clk, rst_n, cmd_o.emit |-> stat_i.out_free)
  `APS_ASSERT(a_last_frees_input, clk, rst_n, (cmd_o.emit && cmd_o.last) |=> (state_r == S_IDLE))
  `APS_ASSERT(a_reject_keeps_phase, clk, rst_n, (cmd_o.emit && cmd_o.sel == SEL_REJ) |=> $stable(phase_r))
  `APS_ASSERT(a_div_pass_order, clk, rst_n, (state_r == S_DIV1 && stat_i.div_done) |=> (state_r == S_DIV2))
  `APS_ASSERT_NEVER(a_no_read_req_on_write, clk, rst_n, cmd_o.emit && cmd_o.sel == SEL_DREQ && stat_i.is_write)

endmodule

### rtl/core/ata_pio_chs_sector_engine.sv
// ----------------------------------------------------------------------------
// ata_pio_chs_sector_engine
// Host-side ATA PIO one-sector read/write engine with LBA to CHS translation
//
//   channel  dir  handshake             payload
//   in_      in   in_valid/in_ready     in_data   (aps_pkg::in_item_t)
//   out_     out  out_valid/out_ready   out_data  (aps_pkg::out_item_t)
//   cfg_     in   cfg_valid/cfg_ready   cfg_index, cfg_data
//
// one request at a time: latch, decide, then one result per cycle into the output register,
// while it has room; status and data requests give 0 to 7 results
// read/write request: adds two serial divisions, by sectors per track and then by heads
// synchronous reset, no clearing pass; cfg_ready is always high
// a stalled output holds only the last result; the next request is taken meanwhile
// ----------------------------------------------------------------------------
module ata_pio_chs_sector_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  aps_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output aps_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aps_pkg::CFG_DATA_W-1:0] cfg_data
);
  import aps_pkg::*;

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  assign cfg_ready = 1'b1;

  aps_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat_i   (dp_stat),
    .cmd_o    (ctrl_cmd)
  );

  aps_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_i     (ctrl_cmd),
    .stat_o    (dp_stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### tb/sv/ata_pio_chs_sector_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_pio_chs_sector_engine_tb
// Drives one-sector PIO reads and writes through the engine and checks every
// task-file write, status/data request, host word and done flag against a
// built-in model of the LBA to CHS split and the transfer phases. A short
// directed table comes first, then mostly well-formed random transfers with
// some stray requests, under several channel bases and disk geometries, with
// random gaps on the request side and random stalls on the result side.
// ----------------------------------------------------------------------------
module ata_pio_chs_sector_engine_tb;
  import aps_pkg::*;

  localparam int N_RANDOM      = 345;
  localparam int SETTLE_CYCLES = 100;
  localparam int DIR_ROWS      = 18;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BUSY,
    PH_READY,
    PH_DATA,
    PH_END
  } xfer_phase_t;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_item_t in_data;
  logic out_valid;
  logic out_ready;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // model of the engine
  logic [15:0] geo_base;
  logic [7:0] geo_spt;
  logic [4:0] geo_heads;
  xfer_phase_t xfer_phase;
  logic xfer_is_write;
  int unsigned xfer_words;
  logic [15:0] chs_cyl;
  logic [3:0] chs_head;
  logic [7:0] chs_sector;

  out_item_t step_results[$];
  out_item_t due_results[$];
  int fail_count = 0;
  int geo_pick = 0;
  bit quiet = 1'b0;
  dir_row_t dir_rows [DIR_ROWS];

  always #1 clk = ~clk;

  ata_pio_chs_sector_engine dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic void put_result(logic [2:0] kind, logic [2:0] off, logic [15:0] val);
    out_item_t r;
    r.kind = kind;
    r.port_address = (kind <= KIND_DREQ) ? geo_base + 16'(off) : 16'h0000;
    r.port_value = val;
    r.last = 1'b0;
    step_results.push_back(r);
  endfunction

  function automatic void engine_step(in_item_t it);
    int unsigned spt;
    int unsigned hc;
    int unsigned q;
    step_results.delete();
    if (xfer_phase == PH_IDLE && (it.cmd == CMD_READ || it.cmd == CMD_WRITE)) begin
      spt = (geo_spt == 8'd0) ? 1 : int'(geo_spt);
      hc = (geo_heads == 5'd0) ? 1 : int'(geo_heads);
      q = it.lba / spt;
      chs_sector = 8'(it.lba % spt + 1);
      chs_head = 4'(q % hc);
      chs_cyl = 16'(q / hc);
      xfer_is_write = (it.cmd == CMD_WRITE);
      xfer_words = 0;
      xfer_phase = PH_BUSY;
      put_result(KIND_SREQ, OFF_CMD_STAT, 16'h0);
    end else if (xfer_phase == PH_BUSY && it.cmd == CMD_STATUS) begin
      if (it.status_byte[ST_BSY]) begin
        put_result(KIND_SREQ, OFF_CMD_STAT, 16'h0);
      end else begin
        put_result(KIND_REG, OFF_COUNT, 16'd1);
        put_result(KIND_REG, OFF_SECTOR, {8'h00, chs_sector});
        put_result(KIND_REG, OFF_CYL_LO, {8'h00, chs_cyl[7:0]});
        put_result(KIND_REG, OFF_CYL_HI, {8'h00, chs_cyl[15:8]});
        put_result(KIND_REG, OFF_DEVICE, {8'h00, DEV_SEL_BASE | {4'h0, chs_head}});
        put_result(KIND_REG, OFF_CMD_STAT,
                   {8'h00, xfer_is_write ? ATA_WRITE_SECTOR : ATA_READ_SECTOR});
        put_result(KIND_SREQ, OFF_CMD_STAT, 16'h0);
        xfer_phase = PH_READY;
      end
    end else if (xfer_phase == PH_READY && it.cmd == CMD_STATUS) begin
      if (!it.status_byte[ST_DRDY]) begin
        put_result(KIND_SREQ, OFF_CMD_STAT, 16'h0);
      end else begin
        xfer_phase = PH_DATA;
        xfer_words = 0;
        if (!xfer_is_write) put_result(KIND_DREQ, OFF_DATA, 16'h0);
      end
    end else if (xfer_phase == PH_DATA && it.cmd == CMD_DATA) begin
      put_result(xfer_is_write ? KIND_DWR : KIND_HOST, OFF_DATA, it.data_word);
      xfer_words++;
      if (xfer_words >= WORDS_PER_SECTOR) begin
        put_result(KIND_SREQ, OFF_CMD_STAT, 16'h0);
        xfer_phase = PH_END;
      end else if (!xfer_is_write) begin
        put_result(KIND_DREQ, OFF_DATA, 16'h0);
      end
    end else if (xfer_phase == PH_END && it.cmd == CMD_STATUS) begin
      if (!it.status_byte[ST_DRDY]) begin
        put_result(KIND_SREQ, OFF_CMD_STAT, 16'h0);
      end else begin
        put_result(KIND_DONE, OFF_DATA, 16'h0);
        xfer_phase = PH_IDLE;
      end
    end else begin
      put_result(KIND_REJ, OFF_DATA, 16'h0);
    end
    if (step_results.size() > 0) step_results[step_results.size() - 1].last = 1'b1;
  endfunction

  function automatic dir_row_t row(logic [1:0] cmd, logic [27:0] lba, logic [15:0] dw,
                                   logic [7:0] st, logic typed, logic [2:0] kind,
                                   logic [15:0] addr);
    dir_row_t d;
    d.item = '{cmd, lba, dw, st};
    d.typed = typed;
    d.res = '{kind, addr, 16'h0000, 1'b1};
    return d;
  endfunction

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    else if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic in_item_t next_item();
    in_item_t it;
    int r;
    it.cmd = 2'($urandom_range(0, 3));
    it.lba = 28'($urandom);
    it.data_word = 16'($urandom);
    it.status_byte = 8'($urandom);
    r = $urandom_range(0, 99);
    // stray request
    if (r < ((xfer_phase == PH_DATA) ? 4 : 10)) return it;
    case (xfer_phase)
      PH_IDLE: begin
        it.cmd = xfer_is_write ? CMD_READ : CMD_WRITE;
        case ($urandom_range(0, 3))
          0: it.lba = 28'($urandom_range(0, 64));
          1: it.lba = 28'hFFFFFFF - 28'($urandom_range(0, 64));
          default: ;
        endcase
      end
      PH_BUSY: begin
        it.cmd = CMD_STATUS;
        it.status_byte[ST_BSY] = ($urandom_range(0, 9) < 3);
      end
      PH_READY, PH_END: begin
        it.cmd = CMD_STATUS;
        it.status_byte[ST_DRDY] = ($urandom_range(0, 9) >= 3);
      end
      default: it.cmd = CMD_DATA;
    endcase
    return it;
  endfunction

  task automatic send_item(in_item_t it, logic typed, out_item_t typed_res);
    int gap;
    gap = quiet ? 0 : idle_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    engine_step(it);
    if (typed) due_results.push_back(typed_res);
    else foreach (step_results[i]) due_results.push_back(step_results[i]);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    // a request may still be dividing or may have no result at all
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_BASE:  geo_base = val;
      CFG_SPT:   geo_spt = val[7:0];
      CFG_HEADS: geo_heads = val[4:0];
      default: ;
    endcase
    @(negedge clk);
  endtask

  task automatic next_geometry();
    logic [15:0] base_v;
    logic [15:0] spt_v;
    logic [15:0] heads_v;
    case (geo_pick)
      0: begin base_v = 16'hFFFF; spt_v = 16'd255; heads_v = 16'd16; end
      1: begin base_v = 16'h0000; spt_v = 16'd1; heads_v = 16'd1; end
      2: begin base_v = 16'hFFFA; spt_v = 16'd0; heads_v = 16'd0; end
      3: begin base_v = 16'h8000; spt_v = 16'd2; heads_v = 16'hFFFF; end
      default: begin
        base_v = 16'($urandom);
        spt_v = 16'($urandom);
        heads_v = 16'($urandom);
      end
    endcase
    geo_pick++;
    drain();
    write_reg(CFG_BASE, base_v);
    write_reg(CFG_SPT, spt_v);
    write_reg(CFG_HEADS, heads_v);
    cfg_valid <= 1'b0;
    quiet = ($urandom_range(0, 3) == 0);
  endtask

  // result side stalls
  initial begin : result_stall
    int run;
    out_ready = 1'b0;
    forever begin
      if (quiet) begin
        out_ready <= 1'b1;
        @(negedge clk);
      end else begin
        run = $urandom_range(1, 16);
        out_ready <= 1'b1;
        repeat (run) @(negedge clk);
        run = ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_ready <= 1'b0;
        repeat (run) @(negedge clk);
      end
    end
  end

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        fail_count++;
        $display("%0t: result expected none got kind %0d addr %h value %h last %b",
                 $time, out_data.kind, out_data.port_address, out_data.port_value,
                 out_data.last);
      end else begin
        want = due_results.pop_front();
        check_field("kind", 16'(want.kind), 16'(out_data.kind));
        check_field("port_address", want.port_address, out_data.port_address);
        check_field("port_value", want.port_value, out_data.port_value);
        check_field("last", 16'(want.last), 16'(out_data.last));
      end
    end
  end

  initial begin : stimulus
    in_item_t it;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    geo_base = BASE_RST;
    geo_spt = SPT_RST;
    geo_heads = HEADS_RST;
    xfer_phase = PH_IDLE;
    xfer_is_write = 1'b0;
    xfer_words = 0;
    chs_cyl = '0;
    chs_head = '0;
    chs_sector = '0;

    // reset geometry, base 0x1f0
    dir_rows = '{
      row(CMD_STATUS, 28'h0000000, 16'h0000, 8'h00, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_DATA, 28'hFFFFFFF, 16'hFFFF, 8'hFF, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_READ, 28'hFFFFFFF, 16'h0000, 8'h00, 1'b1, KIND_SREQ, 16'h01F7),
      row(CMD_WRITE, 28'h0000000, 16'hFFFF, 8'h7F, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_DATA, 28'h0000000, 16'h1234, 8'h00, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_STATUS, 28'h0000000, 16'h0000, 8'hFF, 1'b1, KIND_SREQ, 16'h01F7),
      row(CMD_STATUS, 28'hFFFFFFF, 16'hFFFF, 8'h80, 1'b1, KIND_SREQ, 16'h01F7),
      row(CMD_STATUS, 28'h0000000, 16'h0000, 8'h7F, 1'b0, KIND_REJ, 16'h0000),
      row(CMD_STATUS, 28'h0000000, 16'h0000, 8'h80, 1'b1, KIND_SREQ, 16'h01F7),
      row(CMD_STATUS, 28'h0000000, 16'h0000, 8'hBF, 1'b1, KIND_SREQ, 16'h01F7),
      row(CMD_READ, 28'h0000000, 16'h0000, 8'h40, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_DATA, 28'h0000000, 16'hFFFF, 8'h40, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_STATUS, 28'h0000000, 16'h0000, 8'h40, 1'b1, KIND_DREQ, 16'h01F0),
      row(CMD_STATUS, 28'h0000000, 16'h0000, 8'hFF, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_WRITE, 28'hFFFFFFF, 16'h0000, 8'h00, 1'b1, KIND_REJ, 16'h0000),
      row(CMD_DATA, 28'h0000000, 16'h0000, 8'h00, 1'b0, KIND_REJ, 16'h0000),
      row(CMD_DATA, 28'h0000000, 16'hFFFF, 8'h00, 1'b0, KIND_REJ, 16'h0000),
      row(CMD_DATA, 28'hFFFFFFF, 16'h5A5A, 8'hFF, 1'b0, KIND_REJ, 16'h0000)
    };

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < N_RANDOM; n++) begin
      it = next_item();
      if (n % 64 == 0 ||
          (xfer_phase == PH_IDLE && (it.cmd == CMD_READ || it.cmd == CMD_WRITE)))
        next_geometry();
      send_item(it, 1'b0, '0);
    end

    drain();
    if (fail_count == 0) begin
      $display("ata_pio_chs_sector_engine_tb: PASS");
    end else begin
      $display("ata_pio_chs_sector_engine_tb: FAIL");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("ata_pio_chs_sector_engine_tb: FAIL");
    $finish;
  end

endmodule
